@@ hdl/fifo_thread_scheduler_top_macros.svh @@
// Assertion macros for the checker file of the thread scheduler.
// No dependencies.
`ifndef FIFO_THREAD_SCHEDULER_TOP_MACROS_SVH
`define FIFO_THREAD_SCHEDULER_TOP_MACROS_SVH

// Checked at every clock edge outside reset.
`define FTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ftsched_pkg.sv @@
// Package of the thread scheduler: sizes, command and status codes, and the
// structs between the control and the ready queue. No dependencies.
package ftsched_pkg;

  localparam int MaxThreads = 16;
  localparam int SlotW      = $clog2(MaxThreads);
  localparam int CountW     = $clog2(MaxThreads + 1);
  localparam int CmdW       = 3;
  localparam int StatusW    = 2;

  typedef enum logic [CmdW-1:0] {
    CmdCreate  = 3'd0,
    CmdYield   = 3'd1,
    CmdBlock   = 3'd2,
    CmdUnblock = 3'd3,
    CmdExit    = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatDone     = 2'd0,
    StatFull     = 2'd1,
    StatNoEffect = 2'd2
  } status_e;

  typedef logic [SlotW-1:0] slot_t;

  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
  } q_req_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    slot_t             head_slot;
  } q_stat_t;

endpackage

@@ hdl/ftsched_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ftsched_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ftsched_queue.sv @@
// Circular ready queue: head, tail and fill count around one RAM.
// Depends on ftsched_pkg and ftsched_ram.
module ftsched_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftsched_pkg::q_req_t req_i,
  output ftsched_pkg::q_stat_t stat_o
);

  ftsched_pkg::slot_t                 head_q, head_d, tail_q, tail_d;
  logic [ftsched_pkg::CountW-1:0]     count_q, count_d, count_popped;
  logic                               push_ok;
  ftsched_pkg::slot_t                 head_slot;

  assign count_popped = count_q - ftsched_pkg::CountW'(req_i.pop);
  assign push_ok = req_i.push &&
                   (count_popped < ftsched_pkg::CountW'(ftsched_pkg::MaxThreads));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    if (req_i.pop) begin
      head_d = (head_q == ftsched_pkg::SlotW'(ftsched_pkg::MaxThreads - 1)) ?
               '0 : head_q + 1'b1;
    end
    if (push_ok) begin
      tail_d = (tail_q == ftsched_pkg::SlotW'(ftsched_pkg::MaxThreads - 1)) ?
               '0 : tail_q + 1'b1;
    end
    count_d = count_popped + ftsched_pkg::CountW'(push_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  ftsched_ram #(
    .Width(ftsched_pkg::SlotW),
    .Depth(ftsched_pkg::MaxThreads)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push_ok),
    .waddr_i(tail_q),
    .wdata_i(req_i.push_slot),
    .raddr_i(head_q),
    .rdata_o(head_slot)
  );

  assign stat_o.count     = count_q;
  assign stat_o.head_slot = head_slot;

endmodule

@@ hdl/ftsched_ctrl.sv @@
// Scheduler control: command sequencing, slot state bits and the result item.
// Depends on ftsched_pkg.
module ftsched_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ftsched_pkg::CmdW-1:0] command_i,
  input  ftsched_pkg::slot_t           target_i,
  input  ftsched_pkg::q_stat_t         q_stat_i,
  output ftsched_pkg::q_req_t          q_req_o,
  output logic                         done_o,
  output ftsched_pkg::slot_t           running_o,
  output ftsched_pkg::slot_t           made_o,
  output logic                         switched_o,
  output logic [ftsched_pkg::StatusW-1:0] status_o
);

  typedef enum logic {StIdle, StExec} state_e;

  localparam logic [ftsched_pkg::MaxThreads-1:0] FreeReset =
    {{(ftsched_pkg::MaxThreads - 1){1'b1}}, 1'b0};

  state_e                               state_q, state_d;
  ftsched_pkg::cmd_e                    cmd_q;
  ftsched_pkg::slot_t                   tgt_q;
  ftsched_pkg::slot_t                   cur_q, cur_d;
  logic                                 cur_run_q, cur_run_d;
  logic [ftsched_pkg::MaxThreads-1:0]   free_q, free_d, blocked_q, blocked_d;
  logic                                 done_q;
  ftsched_pkg::slot_t                   running_q, made_q, made_d;
  logic                                 switched_q;
  ftsched_pkg::status_e                 status_q, status_d;
  logic                                 found;
  ftsched_pkg::slot_t                   pick;
  ftsched_pkg::q_req_t                  req;
  logic                                 q_nonempty;

  assign q_nonempty = (q_stat_i.count != '0);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = ftsched_pkg::MaxThreads - 1; i >= 1; i--) begin
      if (free_q[i]) begin
        found = 1'b1;
        pick  = ftsched_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    cur_run_d = cur_run_q;
    free_d    = free_q;
    blocked_d = blocked_q;
    made_d    = '0;
    status_d  = ftsched_pkg::StatDone;
    req       = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        unique case (cmd_q)
          ftsched_pkg::CmdCreate: begin
            if (found) begin
              free_d[pick]  = 1'b0;
              req.push      = 1'b1;
              req.push_slot = pick;
              made_d        = pick;
            end else begin
              status_d = ftsched_pkg::StatFull;
            end
          end
          ftsched_pkg::CmdYield: begin
            if (q_nonempty) begin
              req.pop = 1'b1;
              if (cur_run_q) begin
                req.push      = 1'b1;
                req.push_slot = cur_q;
              end
              cur_d     = q_stat_i.head_slot;
              cur_run_d = 1'b1;
            end else begin
              status_d = ftsched_pkg::StatNoEffect;
            end
          end
          ftsched_pkg::CmdBlock: begin
            blocked_d[cur_q] = 1'b1;
            if (q_nonempty) begin
              req.pop   = 1'b1;
              cur_d     = q_stat_i.head_slot;
              cur_run_d = 1'b1;
            end else begin
              cur_run_d = 1'b0;
            end
          end
          ftsched_pkg::CmdUnblock: begin
            if ((int'(tgt_q) < ftsched_pkg::MaxThreads) && blocked_q[tgt_q]) begin
              blocked_d[tgt_q] = 1'b0;
              if (tgt_q == cur_q) begin
                cur_run_d = 1'b1;
              end else begin
                req.push      = 1'b1;
                req.push_slot = tgt_q;
              end
            end else begin
              status_d = ftsched_pkg::StatNoEffect;
            end
          end
          ftsched_pkg::CmdExit: begin
            if (cur_q == '0) begin
              status_d = ftsched_pkg::StatNoEffect;
            end else begin
              free_d[cur_q]    = 1'b1;
              blocked_d[cur_q] = 1'b0;
              if (q_nonempty) begin
                req.pop = 1'b1;
                cur_d   = q_stat_i.head_slot;
              end else begin
                cur_d = '0;
              end
              blocked_d[cur_d] = 1'b0;
              free_d[cur_d]    = 1'b0;
              cur_run_d        = 1'b1;
            end
          end
          default: begin
            status_d = ftsched_pkg::StatNoEffect;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cmd_q      <= ftsched_pkg::CmdYield;
      tgt_q      <= '0;
      cur_q      <= '0;
      cur_run_q  <= 1'b1;
      free_q     <= FreeReset;
      blocked_q  <= '0;
      done_q     <= 1'b0;
      running_q  <= '0;
      made_q     <= '0;
      switched_q <= 1'b0;
      status_q   <= ftsched_pkg::StatDone;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      cur_run_q <= cur_run_d;
      free_q    <= free_d;
      blocked_q <= blocked_d;
      done_q    <= (state_q == StExec);
      if (state_q == StIdle && start_i) begin
        cmd_q <= ftsched_pkg::cmd_e'(command_i);
        tgt_q <= target_i;
      end
      if (state_q == StExec) begin
        running_q  <= cur_d;
        made_q     <= made_d;
        switched_q <= (cur_d != cur_q);
        status_q   <= status_d;
      end
    end
  end

  assign busy_o     = (state_q == StExec);
  assign q_req_o    = req;
  assign done_o     = done_q;
  assign running_o  = running_q;
  assign made_o     = made_q;
  assign switched_o = switched_q;
  assign status_o   = status_q;

endmodule

@@ hdl/fifo_thread_scheduler_top.sv @@
// Top level of the cooperative FIFO thread scheduler.
// Depends on ftsched_pkg, ftsched_ctrl and ftsched_queue.
//
// Usage: an item (command_i, target_thread_i) is taken at a rising edge with
// start high and busy low. Commands are create, yield, block, unblock and
// exit; codes five to seven only report no effect.
// The result item (running_thread_o, new_thread_o, switched_o, status_o) is
// shown for exactly one cycle with done_o high; the accepting edge registers
// the item and enters the execute state, whose end registers the result. The
// receiver cannot hold it off. In the idle state the head of the ready queue is
// read from its RAM; the execute state updates the slot state and writes the
// queue back. busy is high in the execute state, so a new item can be taken
// only once that state is over, also in the cycle that shows the previous result.
// Reset makes slot 0 (the idle thread) running, all other slots free and the
// ready queue empty. No clearing pass is needed: the queue RAM is read only at
// entries that were written.
module fifo_thread_scheduler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ftsched_pkg::CmdW-1:0]    command_i,
  input  logic [ftsched_pkg::SlotW-1:0]   target_thread_i,
  output logic                            done_o,
  output logic [ftsched_pkg::SlotW-1:0]   running_thread_o,
  output logic [ftsched_pkg::SlotW-1:0]   new_thread_o,
  output logic                            switched_o,
  output logic [ftsched_pkg::StatusW-1:0] status_o
);

  ftsched_pkg::q_req_t  q_req;
  ftsched_pkg::q_stat_t q_stat;

  ftsched_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .command_i (command_i),
    .target_i  (target_thread_i),
    .q_stat_i  (q_stat),
    .q_req_o   (q_req),
    .done_o    (done_o),
    .running_o (running_thread_o),
    .made_o    (new_thread_o),
    .switched_o(switched_o),
    .status_o  (status_o)
  );

  ftsched_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (q_req),
    .stat_o(q_stat)
  );

endmodule

@@ hdl/ftsched_checker.sv @@
// Port-level checker of the thread scheduler and its bind to the top level.
// Depends on ftsched_pkg and fifo_thread_scheduler_top_macros.svh.
`include "fifo_thread_scheduler_top_macros.svh"

module ftsched_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [ftsched_pkg::SlotW-1:0]   new_thread_o,
  input logic                            switched_o,
  input logic [ftsched_pkg::StatusW-1:0] status_o
);

  `FTS_ASSERT(a_accept_to_result, clk_i, rst_ni, start && !busy |=> busy ##1 done_o, "accepted item gave no result two cycles later")
  `FTS_ASSERT(a_single_result, clk_i, rst_ni, done_o |=> !done_o, "result item repeated")
  `FTS_ASSERT(a_failed_is_quiet, clk_i, rst_ni, done_o && status_o != ftsched_pkg::StatDone |-> !switched_o && new_thread_o == '0, "failed event changed the running slot or made one")
  `FTS_ASSERT(a_new_slot_nonidle, clk_i, rst_ni, done_o && new_thread_o != '0 |-> !switched_o, "create switched the running slot")
  `FTS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !busy && !done_o, "activity right after reset")

endmodule

bind fifo_thread_scheduler_top ftsched_checker u_ftsched_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .new_thread_o(new_thread_o),
  .switched_o  (switched_o),
  .status_o    (status_o)
);

@@ tb/sv/fifo_thread_scheduler_top_tb.sv @@
// Self-checking testbench of the FIFO thread scheduler: a directed table, then random events.
// Typed rows are held to the table, others to a cycle-free model of slot states and queue.
// Depends on ftsched_pkg and fifo_thread_scheduler_top.
`timescale 1ns / 1ps

module fifo_thread_scheduler_top_tb;
  import ftsched_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 1020;
  localparam int NumRows     = 15;

  localparam logic [CmdW-1:0] CmdUndefLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUndefHi = 3'd7;

  typedef enum logic [1:0] {
    SlotFree    = 2'd0,
    SlotReady   = 2'd1,
    SlotRunning = 2'd2,
    SlotBlocked = 2'd3
  } slot_state_e;

  typedef struct packed {
    slot_t   running;
    slot_t   created;
    logic    switched;
    status_e status;
  } sched_result_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    slot_t           tgt;
    logic [4:0]      reps;
    logic            typed;
    sched_result_t   want;
  } plan_row_t;

  localparam sched_result_t NoCheck      = '0;
  localparam sched_result_t IdleNoEffect = '{running: '0, created: '0, switched: 1'b0,
                                             status: StatNoEffect};
  localparam sched_result_t IdleDone     = '{running: '0, created: '0, switched: 1'b0,
                                             status: StatDone};
  localparam sched_result_t IdleFull     = '{running: '0, created: '0, switched: 1'b0,
                                             status: StatFull};
  localparam sched_result_t FirstCreate  = '{running: '0, created: 4'd1, switched: 1'b0,
                                             status: StatDone};

  // The idle thread blocks and keeps the processor, is left out of the queue on the
  // next yield, and is dispatched again by an exit on an empty queue. Then the slots fill up.
  localparam plan_row_t Plan [NumRows] = '{
    '{CmdYield,   4'd0,  5'd1,  1'b1, IdleNoEffect},
    '{CmdExit,    4'd0,  5'd1,  1'b1, IdleNoEffect},
    '{CmdUndefHi, 4'd15, 5'd1,  1'b1, IdleNoEffect},
    '{CmdUnblock, 4'd15, 5'd1,  1'b1, IdleNoEffect},
    '{CmdBlock,   4'd0,  5'd1,  1'b1, IdleDone},
    '{CmdUnblock, 4'd0,  5'd1,  1'b1, IdleDone},
    '{CmdBlock,   4'd9,  5'd1,  1'b1, IdleDone},
    '{CmdCreate,  4'd0,  5'd1,  1'b1, FirstCreate},
    '{CmdYield,   4'd0,  5'd1,  1'b0, NoCheck},
    '{CmdExit,    4'd6,  5'd1,  1'b0, NoCheck},
    '{CmdCreate,  4'd0,  5'd15, 1'b0, NoCheck},
    '{CmdCreate,  4'd15, 5'd1,  1'b1, IdleFull},
    '{CmdBlock,   4'd0,  5'd1,  1'b0, NoCheck},
    '{CmdUnblock, 4'd0,  5'd1,  1'b0, NoCheck},
    '{CmdExit,    4'd0,  5'd1,  1'b0, NoCheck}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CmdW-1:0]   command_i;
  slot_t             target_thread_i;
  logic              done_o;
  slot_t             running_thread_o;
  slot_t             new_thread_o;
  logic              switched_o;
  logic [StatusW-1:0] status_o;

  slot_state_e       thr_state [MaxThreads];
  slot_t             ready_ring [MaxThreads];
  slot_t             ring_head;
  slot_t             ring_tail;
  int                ring_count;
  slot_t             cur_slot;

  sched_result_t     sched_results_q [$];
  int                fail_count  = 0;
  int                result_count = 0;
  int                cycle_count = 0;
  bit                no_gaps     = 1'b0;

  fifo_thread_scheduler_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .target_thread_i  (target_thread_i),
    .done_o           (done_o),
    .running_thread_o (running_thread_o),
    .new_thread_o     (new_thread_o),
    .switched_o       (switched_o),
    .status_o         (status_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void ring_push(input slot_t s);
    if (ring_count < MaxThreads) begin
      ready_ring[ring_tail] = s;
      ring_tail = (ring_tail == slot_t'(MaxThreads - 1)) ? '0 : ring_tail + 1'b1;
      ring_count++;
    end
  endfunction

  function automatic slot_t ring_pop();
    slot_t s;
    s = ready_ring[ring_head];
    ring_head = (ring_head == slot_t'(MaxThreads - 1)) ? '0 : ring_head + 1'b1;
    ring_count--;
    return s;
  endfunction

  function automatic status_e dispatch_next();
    slot_t nxt;
    if (ring_count == 0) begin
      return StatNoEffect;
    end
    nxt = ring_pop();
    if (thr_state[cur_slot] == SlotRunning) begin
      thr_state[cur_slot] = SlotReady;
      ring_push(cur_slot);
    end
    thr_state[nxt] = SlotRunning;
    cur_slot = nxt;
    return StatDone;
  endfunction

  function automatic sched_result_t schedule_event(input logic [CmdW-1:0] cmd, input slot_t tgt);
    sched_result_t r;
    slot_t prior;
    prior = cur_slot;
    r = '0;
    r.status = StatDone;
    case (cmd)
      CmdCreate: begin
        r.status = StatFull;
        for (int i = 1; i < MaxThreads; i++) begin
          if (r.status == StatFull && thr_state[i] == SlotFree) begin
            thr_state[i] = SlotReady;
            ring_push(slot_t'(i));
            r.created = slot_t'(i);
            r.status = StatDone;
          end
        end
      end
      CmdYield: r.status = dispatch_next();
      CmdBlock: begin
        thr_state[cur_slot] = SlotBlocked;
        void'(dispatch_next());
      end
      CmdUnblock: begin
        if (thr_state[tgt] == SlotBlocked) begin
          if (tgt == cur_slot) begin
            thr_state[tgt] = SlotRunning;
          end else begin
            thr_state[tgt] = SlotReady;
            ring_push(tgt);
          end
        end else begin
          r.status = StatNoEffect;
        end
      end
      CmdExit: begin
        if (cur_slot == '0) begin
          r.status = StatNoEffect;
        end else begin
          thr_state[cur_slot] = SlotFree;
          cur_slot = (ring_count > 0) ? ring_pop() : '0;
          thr_state[cur_slot] = SlotRunning;
        end
      end
      default: r.status = StatNoEffect;
    endcase
    r.running = cur_slot;
    r.switched = (cur_slot != prior);
    return r;
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input slot_t tgt, input logic typed,
                           input sched_result_t want);
    sched_result_t predicted;
    if (!no_gaps && $urandom_range(99) < 21) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy || $urandom_range(99) < 21);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    target_thread_i <= tgt;
    do @(posedge clk_i); while (busy);
    predicted = schedule_event(cmd, tgt);
    sched_results_q.push_back(typed ? want : predicted);
  endtask

  initial begin : stimulus
    int              create_pct;
    int              roll;
    int              first;
    logic [CmdW-1:0] cmd;
    slot_t           tgt;
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    command_i       <= CmdCreate;
    target_thread_i <= '0;
    for (int i = 0; i < MaxThreads; i++) begin
      thr_state[i]  = SlotFree;
      ready_ring[i] = '0;
    end
    thr_state[0] = SlotRunning;
    ring_head    = '0;
    ring_tail    = '0;
    ring_count   = 0;
    cur_slot     = '0;
    create_pct   = 30;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < Plan[r].reps; k++) begin
        send_item(Plan[r].cmd, Plan[r].tgt, Plan[r].typed, Plan[r].want);
      end
    end

    // The mix of creates changes every 150 items so that the slots run both full and empty.
    for (int n = 0; n < RandomItems; n++) begin
      no_gaps = (n >= 400 && n < 600);
      if (n % 150 == 0) begin
        case ($urandom_range(2))
          0:       create_pct = 8;
          1:       create_pct = 30;
          default: create_pct = 55;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        cmd = CmdW'($urandom_range(CmdUndefHi, CmdUndefLo));
      end else if (roll < 3 + create_pct) begin
        cmd = CmdCreate;
      end else begin
        case ($urandom_range(3))
          0:       cmd = CmdYield;
          1:       cmd = CmdBlock;
          2:       cmd = CmdUnblock;
          default: cmd = CmdExit;
        endcase
      end
      tgt = slot_t'($urandom_range(MaxThreads - 1));
      if (cmd == CmdUnblock && $urandom_range(1) == 1) begin
        first = $urandom_range(MaxThreads - 1);
        for (int j = 0; j < MaxThreads; j++) begin
          if (thr_state[(first + j) % MaxThreads] == SlotBlocked) begin
            tgt = slot_t'((first + j) % MaxThreads);
          end
        end
      end
      send_item(cmd, tgt, 1'b0, NoCheck);
    end
    start <= 1'b0;

    while (sched_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[fifo_thread_scheduler_top] OK");
    end else begin
      $display("[fifo_thread_scheduler_top] ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    sched_result_t got;
    if (rst_ni && done_o) begin
      got.running  = running_thread_o;
      got.created  = new_thread_o;
      got.switched = switched_o;
      got.status   = status_e'(status_o);
      if (sched_results_q.size() == 0) begin
        if (fail_count < 10) begin
          $display("result %0d arrived with no item outstanding", result_count);
        end
        fail_count++;
      end else begin
        want = sched_results_q.pop_front();
        if (got.running != want.running || got.created != want.created ||
            got.switched != want.switched || got.status != want.status) begin
          if (fail_count < 10) begin
            $display("result %0d: running %0d/%0d new %0d/%0d switched %0b/%0b status %0d/%0d",
                     result_count, want.running, got.running, want.created, got.created,
                     want.switched, got.switched, want.status, got.status);
          end
          fail_count++;
        end
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[fifo_thread_scheduler_top] ERROR");
      $finish;
    end
  end

endmodule
